// ===== rtl/abc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bit crusher package
// Shared types and fixed constants of the audio bit crusher.
// ----------------------------------------------------------------------------
package abc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BYPASS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_BITS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WET_AMOUNT  = 3'd5;

  localparam logic [3:0]  RST_DEPTH_BITS  = 4'd8;
  localparam logic [7:0]  RST_HOLD_RATE   = 8'd1;
  localparam logic [15:0] RST_INPUT_GAIN  = 16'd4096;
  localparam logic [15:0] RST_OUTPUT_GAIN = 16'd4096;
  localparam logic [8:0]  RST_WET_AMOUNT  = 9'd256;

  localparam logic [8:0] WET_FULL   = 9'd256;
  localparam int         GAIN_SHIFT = 12;
  localparam int         MIX_SHIFT  = 8;
  localparam int         COEF_W     = 17;

  localparam logic [2:0] STEP_NONE    = 3'd0;
  localparam logic [2:0] STEP_IN_MUL  = 3'd1;
  localparam logic [2:0] STEP_IN_SAT  = 3'd2;
  localparam logic [2:0] STEP_MIX_A   = 3'd3;
  localparam logic [2:0] STEP_MIX_B   = 3'd4;
  localparam logic [2:0] STEP_MIX_SUM = 3'd5;
  localparam logic [2:0] STEP_OUT_MUL = 3'd6;
  localparam logic [2:0] STEP_OUT_SAT = 3'd7;

  typedef struct packed {
    logic        bypass;
    logic [3:0]  depth_bits;
    logic [7:0]  hold_rate;
    logic [15:0] input_gain;
    logic [15:0] output_gain;
    logic [8:0]  wet_amount;
  } cfg_t;

  typedef struct packed {
    logic       load_in;
    logic [2:0] step;
    logic       load_out;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/abc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bit crusher input channel
// Valid/ready channel carrying one audio sample and its block start flag.
// ----------------------------------------------------------------------------
interface abc_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;
  logic                block_first;

  modport source (output valid, output sample_in, output block_first, input ready);
  modport sink   (input valid, input sample_in, input block_first, output ready);
endinterface
`default_nettype wire

// ===== rtl/abc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bit crusher output channel
// Valid/ready channel carrying one processed audio sample.
// ----------------------------------------------------------------------------
interface abc_out_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/abc_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bit crusher configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface abc_cfg_if;
  import abc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/audio_bit_crusher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Audio bit crusher
// Input gain, bit-depth reduction, wet/dry mix, sample hold and output gain.
// ----------------------------------------------------------------------------
// Each sample passes through the seven steps of the controller around one
// shared multiplier (input gain, two mix products, output gain) and is then
// handed to the output register once that register is free. In bypass the
// sample is written straight to the result register and skips the steps.
// The next sample is taken as soon as the result moves to the output
// register, so the block takes no new sample while one is still in the steps.
// A new sample can start while the previous result still waits there.
// Configuration is written through its own channel, which is always ready.
module audio_bit_crusher #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  abc_in_if.sink    in_s,
  abc_out_if.source out_m,
  abc_cfg_if.sink   cfg_s
);
  import abc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  abc_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_s (cfg_s),
    .cfg   (cfg)
  );

  abc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_ready  (in_s.ready),
    .out_valid (out_m.valid),
    .out_ready (out_m.ready),
    .bypass    (cfg.bypass),
    .cmd       (cmd)
  );

  abc_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (cmd),
    .sample_in   (in_s.sample_in),
    .block_first (in_s.block_first),
    .sample_out  (out_m.sample_out)
  );

endmodule
`default_nettype wire

// ===== rtl/abc_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bit crusher configuration registers
// Holds the six control registers written through the configuration channel.
// ----------------------------------------------------------------------------
module abc_cfg_regs (
  input  wire logic  clk,
  input  wire logic  rst_n,
  abc_cfg_if.sink    cfg_s,
  output abc_pkg::cfg_t cfg
);
  import abc_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_s.ready = 1'b1;
  assign cfg         = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_s.valid) begin
      case (cfg_s.index)
        REG_BYPASS:      cfg_nxt.bypass      = cfg_s.data[0];
        REG_DEPTH_BITS:  cfg_nxt.depth_bits  = cfg_s.data[3:0];
        REG_HOLD_RATE:   cfg_nxt.hold_rate   = cfg_s.data[7:0];
        REG_INPUT_GAIN:  cfg_nxt.input_gain  = cfg_s.data;
        REG_OUTPUT_GAIN: cfg_nxt.output_gain = cfg_s.data;
        REG_WET_AMOUNT:  cfg_nxt.wet_amount  = cfg_s.data[8:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bypass      <= 1'b0;
      cfg_r.depth_bits  <= RST_DEPTH_BITS;
      cfg_r.hold_rate   <= RST_HOLD_RATE;
      cfg_r.input_gain  <= RST_INPUT_GAIN;
      cfg_r.output_gain <= RST_OUTPUT_GAIN;
      cfg_r.wet_amount  <= RST_WET_AMOUNT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/abc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bit crusher controller
// Sequences the shared multiplier steps and the output register handoff.
// ----------------------------------------------------------------------------
module abc_ctrl (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire logic  bypass,
  output abc_pkg::cmd_t cmd
);
  import abc_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_IN_MUL  = 4'd1;
  localparam logic [3:0] ST_IN_SAT  = 4'd2;
  localparam logic [3:0] ST_MIX_A   = 4'd3;
  localparam logic [3:0] ST_MIX_B   = 4'd4;
  localparam logic [3:0] ST_MIX_SUM = 4'd5;
  localparam logic [3:0] ST_OUT_MUL = 4'd6;
  localparam logic [3:0] ST_OUT_SAT = 4'd7;
  localparam logic [3:0] ST_DONE    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.load_in   = 1'b0;
    cmd.step      = STEP_NONE;
    cmd.load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_in = 1'b1;
          state_nxt   = bypass ? ST_DONE : ST_IN_MUL;
        end
      end
      ST_IN_MUL: begin
        cmd.step  = STEP_IN_MUL;
        state_nxt = ST_IN_SAT;
      end
      ST_IN_SAT: begin
        cmd.step  = STEP_IN_SAT;
        state_nxt = ST_MIX_A;
      end
      ST_MIX_A: begin
        cmd.step  = STEP_MIX_A;
        state_nxt = ST_MIX_B;
      end
      ST_MIX_B: begin
        cmd.step  = STEP_MIX_B;
        state_nxt = ST_MIX_SUM;
      end
      ST_MIX_SUM: begin
        cmd.step  = STEP_MIX_SUM;
        state_nxt = ST_OUT_MUL;
      end
      ST_OUT_MUL: begin
        cmd.step  = STEP_OUT_MUL;
        state_nxt = ST_OUT_SAT;
      end
      ST_OUT_SAT: begin
        cmd.step  = STEP_OUT_SAT;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> slot_free)
    else $error("output register loaded while holding an untaken result");

  a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (bypass ? (state_r == ST_DONE) : (state_r == ST_IN_MUL)))
    else $error("accepted sample did not enter the expected path");

  a_done_hands_off: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && slot_free |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("finished result was not handed to the output register");

endmodule
`default_nettype wire

// ===== rtl/abc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bit crusher datapath
// Gain, quantizer, wet/dry mix and sample hold around one shared multiplier.
// ----------------------------------------------------------------------------
module abc_datapath #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire abc_pkg::cfg_t                  cfg,
  input  wire abc_pkg::cmd_t                  cmd,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  wire logic                           block_first,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);
  import abc_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = SW + COEF_W;
  localparam logic signed [PW-1:0] SMAX = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN = ~SMAX;
  localparam logic [5:0] FRAC_BITS = 6'(SW - 1);

  logic signed [SW-1:0] x_r;
  logic signed [SW-1:0] gained_r, gained_nxt;
  logic signed [SW-1:0] held_r, held_nxt;
  logic signed [SW-1:0] mixed_r, mixed_nxt;
  logic signed [SW-1:0] result_r, result_nxt;
  logic signed [SW-1:0] out_r;
  logic signed [PW-1:0] prod_r, acc_r, prod_nxt;
  logic [7:0]           pos_r, pos_nxt;
  logic                 first_r, first_nxt;

  logic [7:0]           rate, pos_base, pos_eff;
  logic [8:0]           pos_inc;
  logic [8:0]           wet, dry;
  logic [5:0]           drop;
  logic [SW-1:0]        keep_mask;
  logic signed [SW-1:0] crushed;
  logic signed [SW-1:0] op_a;
  logic signed [COEF_W-1:0] op_b;
  logic signed [PW-1:0] gain_sh, sum, mix_sh;
  logic signed [SW-1:0] gain_sat;

  assign rate = (cfg.hold_rate == 8'd0) ? 8'd1 : cfg.hold_rate;
  assign wet  = (cfg.wet_amount > WET_FULL) ? WET_FULL : cfg.wet_amount;
  assign dry  = WET_FULL - wet;
  assign drop = ({2'b00, cfg.depth_bits} < FRAC_BITS)
              ? (FRAC_BITS - {2'b00, cfg.depth_bits}) : 6'd0;
  assign keep_mask = {SW{1'b1}} << drop;
  assign crushed   = gained_r & keep_mask;

  assign gain_sh  = prod_r >>> GAIN_SHIFT;
  assign gain_sat = (gain_sh > SMAX) ? SMAX[SW-1:0]
                  : (gain_sh < SMIN) ? SMIN[SW-1:0] : gain_sh[SW-1:0];
  assign sum      = acc_r + prod_r;
  assign mix_sh   = sum >>> MIX_SHIFT;

  always_comb begin
    op_a = x_r;
    op_b = COEF_W'({1'b0, cfg.input_gain});
    case (cmd.step)
      STEP_MIX_A: begin
        op_a = first_r ? crushed : held_r;
        op_b = COEF_W'(wet);
      end
      STEP_MIX_B: begin
        op_a = gained_r;
        op_b = COEF_W'(dry);
      end
      STEP_OUT_MUL: begin
        op_a = mixed_r;
        op_b = COEF_W'({1'b0, cfg.output_gain});
      end
      default: begin
        op_a = x_r;
        op_b = COEF_W'({1'b0, cfg.input_gain});
      end
    endcase
  end

  assign prod_nxt = op_a * op_b;

  always_comb begin
    pos_base  = block_first ? 8'd0 : pos_r;
    pos_eff   = (pos_base >= rate) ? 8'd0 : pos_base;
    pos_inc   = {1'b0, pos_eff} + 9'd1;
    pos_nxt   = pos_r;
    first_nxt = first_r;
    if (cmd.load_in) begin
      if (cfg.bypass) begin
        pos_nxt = pos_base;
      end else begin
        first_nxt = (pos_eff == 8'd0);
        pos_nxt   = (pos_inc >= {1'b0, rate}) ? 8'd0 : pos_inc[7:0];
      end
    end
  end

  always_comb begin
    gained_nxt = gained_r;
    held_nxt   = held_r;
    mixed_nxt  = mixed_r;
    result_nxt = result_r;
    if (cmd.load_in && cfg.bypass) begin
      result_nxt = sample_in;
    end
    case (cmd.step)
      STEP_IN_SAT:  gained_nxt = gain_sat;
      STEP_MIX_SUM: begin
        mixed_nxt = mix_sh[SW-1:0];
        if (first_r) begin
          held_nxt = mix_sh[SW-1:0];
        end
      end
      STEP_OUT_SAT: result_nxt = gain_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 8'd0;
      held_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r <= sample_in;
    end
    if (cmd.step == STEP_IN_MUL || cmd.step == STEP_MIX_A ||
        cmd.step == STEP_MIX_B  || cmd.step == STEP_OUT_MUL) begin
      prod_r <= prod_nxt;
    end
    if (cmd.step == STEP_MIX_B) begin
      acc_r <= prod_r;
    end
    if (cmd.load_out) begin
      out_r <= result_r;
    end
    first_r  <= first_nxt;
    gained_r <= gained_nxt;
    mixed_r  <= mixed_nxt;
    result_r <= result_nxt;
  end

  assign sample_out = out_r;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio bit crusher testbench
// Drives samples and register writes over valid/ready channels, predicts
// every processed sample in order and compares it with the transfer out.
// A directed table comes first, then random blocks of samples under
// changing register settings and four sender/receiver idling phases.
// ----------------------------------------------------------------------------
module tb;
  import abc_pkg::*;

  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  first;
    logic                  has_exp;
    logic signed [15:0]    exp_val;
  } dir_row_t;

  logic clk;
  logic rst_n;

  abc_in_if  #(.W(16)) in_ch ();
  abc_out_if #(.W(16)) out_ch ();
  abc_cfg_if           cfg_ch ();

  audio_bit_crusher #(.SAMPLE_WIDTH(16)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch),
    .cfg_s (cfg_ch)
  );

  // Predictor copy of the registers and the hold state.
  logic        cfg_bypass  = 1'b0;
  logic [3:0]  cfg_depth   = RST_DEPTH_BITS;
  logic [7:0]  cfg_hold    = RST_HOLD_RATE;
  logic [15:0] cfg_in_gain = RST_INPUT_GAIN;
  logic [15:0] cfg_out_gain = RST_OUTPUT_GAIN;
  logic [8:0]  cfg_wet     = RST_WET_AMOUNT;
  longint      held_val    = 0;
  int          grp_pos     = 0;

  logic signed [15:0] pending_q [$];
  int                 mismatch_cnt = 0;
  int                 send_idle  = 0;
  int                 recv_stall = 0;
  logic               drv_has_exp = 1'b0;
  logic signed [15:0] drv_exp = '0;
  dir_row_t           dir_tab [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic signed [15:0] predict_crushed(logic signed [15:0] smp,
                                                         logic first);
    longint x, gained, crushed, mixed, w, ig, og;
    int     rate, drop;
    if (first) grp_pos = 0;
    if (cfg_bypass) return smp;
    rate = (cfg_hold == 0) ? 1 : int'(cfg_hold);
    if (grp_pos >= rate) grp_pos = 0;
    x  = smp;
    ig = longint'(cfg_in_gain);
    og = longint'(cfg_out_gain);
    w  = (cfg_wet > WET_FULL) ? longint'(WET_FULL) : longint'(cfg_wet);
    gained = sat16((x * ig) >>> GAIN_SHIFT);
    drop = (cfg_depth < 15) ? 15 - int'(cfg_depth) : 0;
    crushed = (gained >>> drop) <<< drop;
    if (grp_pos == 0) begin
      mixed = (crushed * w + gained * (256 - w)) >>> MIX_SHIFT;
      held_val = mixed;
    end else begin
      mixed = (held_val * w + gained * (256 - w)) >>> MIX_SHIFT;
    end
    grp_pos++;
    if (grp_pos >= rate) grp_pos = 0;
    return 16'(sat16((mixed * og) >>> GAIN_SHIFT));
  endfunction

  function automatic dir_row_t smp_row(logic signed [15:0] smp, logic first,
                                       logic has_exp, logic signed [15:0] ev);
    dir_row_t r;
    r.kind    = ROW_SMP;
    r.idx     = '0;
    r.val     = smp;
    r.first   = first;
    r.has_exp = has_exp;
    r.exp_val = ev;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r.kind    = ROW_CFG;
    r.idx     = idx;
    r.val     = val;
    r.first   = 1'b0;
    r.has_exp = 1'b0;
    r.exp_val = '0;
    return r;
  endfunction

  task automatic flag_error(string msg);
    if (mismatch_cnt < 10) $display("%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Transfer monitor: predicts on every accepted sample, checks every result.
  always @(posedge clk) begin : transfer_mon
    logic signed [15:0] want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = predict_crushed(in_ch.sample_in, in_ch.block_first);
        if (drv_has_exp) want = drv_exp;
        pending_q.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          flag_error($sformatf("unexpected sample_out %0d", out_ch.sample_out));
        end else begin
          want = pending_q.pop_front();
          if (want !== out_ch.sample_out)
            flag_error($sformatf("sample_out expected %0d got %0d",
                                 want, out_ch.sample_out));
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= recv_stall);
  end

  task automatic send_sample(logic signed [15:0] smp, logic first,
                             logic has_exp, logic signed [15:0] ev);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.sample_in   = smp;
    in_ch.block_first = first;
    drv_has_exp       = has_exp;
    drv_exp           = ev;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    drv_has_exp = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_BYPASS:      cfg_bypass   = val[0];
      REG_DEPTH_BITS:  cfg_depth    = val[3:0];
      REG_HOLD_RATE:   cfg_hold     = val[7:0];
      REG_INPUT_GAIN:  cfg_in_gain  = val[15:0];
      REG_OUTPUT_GAIN: cfg_out_gain = val[15:0];
      REG_WET_AMOUNT:  cfg_wet      = val[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1024, 8192));
    endcase
  endfunction

  task automatic load_settings(int flavor);
    logic        bp;
    logic [3:0]  dp;
    logic [7:0]  hr;
    logic [15:0] ig, og;
    logic [8:0]  wt;
    bp = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 3))
      0: dp = 4'd0;
      1: dp = 4'd15;
      default: dp = 4'($urandom_range(0, 15));
    endcase
    case ($urandom_range(0, 5))
      0: hr = 8'd0;
      1: hr = 8'd255;
      2: hr = 8'($urandom_range(0, 255));
      default: hr = 8'($urandom_range(1, 8));
    endcase
    ig = pick_gain();
    og = pick_gain();
    case ($urandom_range(0, 4))
      0: wt = 9'd0;
      1: wt = WET_FULL;
      2: wt = 9'($urandom_range(257, 511));
      default: wt = 9'($urandom_range(0, 256));
    endcase
    if (flavor == 1) begin
      bp = 1'b0; dp = 4'd15; hr = 8'd255; ig = 16'hFFFF; og = 16'hFFFF; wt = WET_FULL;
    end else if (flavor == 2) begin
      bp = 1'b0; dp = 4'd1; hr = 8'd1; ig = 16'd0; og = 16'd0; wt = 9'd0;
    end
    cfg_write(REG_BYPASS, 16'(bp));
    cfg_write(REG_DEPTH_BITS, 16'(dp));
    cfg_write(REG_HOLD_RATE, 16'(hr));
    cfg_write(REG_INPUT_GAIN, ig);
    cfg_write(REG_OUTPUT_GAIN, og);
    cfg_write(REG_WET_AMOUNT, 16'(wt));
  endtask

  function automatic logic signed [15:0] pick_sample();
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'sh7FFF;
      1: v = 16'sh8000;
      2, 3: begin
        v = 16'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int       blk_left;
    logic     first;
    dir_row_t row;
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.sample_in   = '0;
    in_ch.block_first = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_BYPASS;
    cfg_ch.data       = '0;
    blk_left          = 0;

    dir_tab.push_back(smp_row(0, 1'b1, 1'b1, 0));
    dir_tab.push_back(smp_row(32767, 1'b0, 1'b1, 32640));
    dir_tab.push_back(smp_row(-32768, 1'b0, 1'b1, -32768));
    dir_tab.push_back(smp_row(-1, 1'b0, 1'b1, -128));
    dir_tab.push_back(smp_row(1000, 1'b0, 1'b0, 0));
    dir_tab.push_back(cfg_row(REG_BYPASS, 16'd1));
    dir_tab.push_back(smp_row(12345, 1'b1, 1'b1, 12345));
    dir_tab.push_back(smp_row(-32768, 1'b0, 1'b1, -32768));
    dir_tab.push_back(cfg_row(REG_BYPASS, 16'd0));
    dir_tab.push_back(cfg_row(REG_DEPTH_BITS, 16'd0));
    dir_tab.push_back(smp_row(100, 1'b0, 1'b1, 0));
    dir_tab.push_back(smp_row(-5, 1'b0, 1'b1, -32768));
    dir_tab.push_back(cfg_row(REG_DEPTH_BITS, 16'd15));
    dir_tab.push_back(cfg_row(REG_INPUT_GAIN, 16'hFFFF));
    dir_tab.push_back(smp_row(20000, 1'b0, 1'b1, 32767));
    dir_tab.push_back(smp_row(-20000, 1'b0, 1'b1, -32768));
    dir_tab.push_back(cfg_row(REG_INPUT_GAIN, 16'd0));
    dir_tab.push_back(smp_row(1234, 1'b0, 1'b1, 0));
    dir_tab.push_back(cfg_row(REG_INPUT_GAIN, 16'd4096));
    dir_tab.push_back(cfg_row(REG_OUTPUT_GAIN, 16'd0));
    dir_tab.push_back(smp_row(-32768, 1'b0, 1'b1, 0));
    dir_tab.push_back(cfg_row(REG_OUTPUT_GAIN, 16'hFFFF));
    dir_tab.push_back(smp_row(3000, 1'b0, 1'b0, 0));
    dir_tab.push_back(cfg_row(REG_DEPTH_BITS, 16'd4));
    dir_tab.push_back(cfg_row(REG_WET_AMOUNT, 16'd300));
    dir_tab.push_back(cfg_row(REG_HOLD_RATE, 16'd0));
    dir_tab.push_back(smp_row(7777, 1'b1, 1'b0, 0));
    dir_tab.push_back(smp_row(-7777, 1'b0, 1'b0, 0));
    dir_tab.push_back(cfg_row(REG_WET_AMOUNT, 16'd0));
    dir_tab.push_back(cfg_row(REG_OUTPUT_GAIN, 16'd4096));
    dir_tab.push_back(smp_row(-9999, 1'b0, 1'b0, 0));
    dir_tab.push_back(cfg_row(REG_WET_AMOUNT, 16'd128));
    dir_tab.push_back(cfg_row(REG_HOLD_RATE, 16'd255));
    dir_tab.push_back(smp_row(1111, 1'b1, 1'b0, 0));
    dir_tab.push_back(smp_row(2222, 1'b0, 1'b0, 0));
    dir_tab.push_back(smp_row(3333, 1'b0, 1'b0, 0));
    dir_tab.push_back(smp_row(4444, 1'b0, 1'b0, 0));
    dir_tab.push_back(cfg_row(REG_HOLD_RATE, 16'd2));
    dir_tab.push_back(smp_row(5555, 1'b0, 1'b0, 0));
    dir_tab.push_back(smp_row(6666, 1'b0, 1'b0, 0));
    dir_tab.push_back(smp_row(7777, 1'b0, 1'b0, 0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG) begin
        settle();
        cfg_write(row.idx, row.val);
      end else begin
        send_sample(row.val, row.first, row.has_exp, row.exp_val);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 57; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 57; end
        default: begin send_idle = 12; recv_stall = 12; end
      endcase
      for (int s = 0; s < 3; s++) begin
        settle();
        load_settings((s == 0 && phase < 2) ? phase + 1 : 0);
        blk_left = 0;
        for (int n = 0; n < 125; n++) begin
          if ($urandom_range(0, 299) == 0) settle();
          if ($urandom_range(0, 15) == 0) begin
            first = 1'($urandom_range(0, 1));
          end else if (blk_left == 0) begin
            first = 1'b1;
            blk_left = $urandom_range(1, 2 * int'(cfg_hold) + 2);
          end else begin
            first = 1'b0;
          end
          if (blk_left > 0) blk_left--;
          send_sample(pick_sample(), first, 1'b0, 16'sd0);
        end
      end
    end

    settle();
    if (mismatch_cnt == 0 && pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== audio_bit_crusher.f =====
rtl/abc_pkg.sv
rtl/abc_in_if.sv
rtl/abc_out_if.sv
rtl/abc_cfg_if.sv
rtl/abc_cfg_regs.sv
rtl/abc_ctrl.sv
rtl/abc_datapath.sv
rtl/audio_bit_crusher.sv
tb/sv/tb.sv
